>>> rtl/hrc_pkg.sv
// Shared types and constants for the HSV/RGB pixel converter.
// No dependencies; imported by the converter modules.
package hrc_pkg;

  localparam int CHANNEL_BITS_DEF = 16;

  // Conversion direction carried with each word.
  typedef enum logic {
    KIND_TO_HSV = 1'b0,
    KIND_TO_RGB = 1'b1
  } kind_e;

  // Hue sector, one sixth of a turn each.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    MAX_RED = 2'd0,
    MAX_GRN = 2'd1,
    MAX_BLU = 2'd2
  } max_ch_e;

endpackage

>>> rtl/hrc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
// No package dependencies.
module hrc_div #(
  parameter int W  = 35,
  parameter int DW = 19,
  parameter int QB = 17,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [PW-1:0] pay_i,
  output logic [QB-1:0] quot_o,
  output logic [PW-1:0] pay_o
);

  localparam int XW = DW + QB;

  logic [W-1:0]  rem_q [QB-1];
  logic [DW-1:0] dvs_q [QB-1];
  logic [QB-1:0] quo_q [QB];
  logic [PW-1:0] pay_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int B = QB - 1 - j;
    logic [W-1:0]  rem_in;
    logic [DW-1:0] dvs_in;
    logic [QB-1:0] quo_in;
    logic [PW-1:0] pay_in;
    logic [XW-1:0] trial;
    logic [XW-1:0] remx;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = dividend_i;
      assign dvs_in = divisor_i;
      assign quo_in = '0;
      assign pay_in = pay_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dvs_in = dvs_q[j-1];
      assign quo_in = quo_q[j-1];
      assign pay_in = pay_q[j-1];
    end

    assign trial = XW'(dvs_in) << B;
    assign remx  = XW'(rem_in);
    assign ge    = (remx >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pay_q[j] <= '0;
      end else if (en_i) begin
        pay_q[j] <= pay_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= quo_in | (ge ? (QB'(1) << B) : QB'(0));
      end
    end

    if (j < QB - 1) begin : g_rem
      logic [XW-1:0] diff;
      assign diff = remx - trial;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? diff[W-1:0] : rem_in;
          dvs_q[j] <= dvs_in;
        end
      end
    end
  end

  assign quot_o = quo_q[QB-1];
  assign pay_o  = pay_q[QB-1];

endmodule

>>> rtl/hrc_hsv2rgb.sv
// Four-stage HSV to RGB datapath: sector split, products, mixes, select.
// Depends on hrc_pkg (sector codes).
module hrc_hsv2rgb
  import hrc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int PW = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [CHANNEL_BITS-1:0] hue_i,
  input  logic [CHANNEL_BITS-1:0] sat_i,
  input  logic [CHANNEL_BITS-1:0] val_i,
  input  logic [PW-1:0]           pay_i,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o,
  output logic [PW-1:0]           pay_o
);

  localparam int C = CHANNEL_BITS;
  localparam logic [C-1:0]   ONE    = {C{1'b1}};
  localparam logic [2*C:0]   HALF_M = (2*C+1)'((64'd1 << (C-1)) - 64'd1);
  localparam logic [2*C:0]   HALF   = (2*C+1)'(64'd1 << (C-1));
  localparam logic [C:0]     TURN   = (C+1)'(64'd1 << C);

  // round(prod / ONE), ONE = 2^C - 1, by reciprocal add-and-shift
  function automatic logic [C-1:0] mul_fix(input logic [2*C-1:0] prod);
    logic [2*C:0] x;
    logic [2*C:0] y;
    x = {1'b0, prod} + HALF_M;
    y = x + (x >> C) + (2*C+1)'(1);
    return y[2*C-1:C];
  endfunction

  // stage A
  logic [C+2:0] p;
  logic [2:0]   a_sec_q;
  logic [C-1:0] a_f_q, a_s_q, a_v_q, a_oms_q;
  logic         a_black_q, a_grey_q;
  logic [PW-1:0] a_pay_q, b_pay_q, c_pay_q, d_pay_q;

  assign p = ({3'b0, hue_i} << 2) + ({3'b0, hue_i} << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_pay_q <= '0;
      b_pay_q <= '0;
      c_pay_q <= '0;
      d_pay_q <= '0;
    end else if (en_i) begin
      a_pay_q <= pay_i;
      b_pay_q <= a_pay_q;
      c_pay_q <= b_pay_q;
      d_pay_q <= c_pay_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_sec_q   <= p[C+2:C];
      a_f_q     <= p[C-1:0];
      a_s_q     <= sat_i;
      a_v_q     <= val_i;
      a_oms_q   <= ONE - sat_i;
      a_black_q <= (val_i == '0);
      a_grey_q  <= (sat_i == '0);
    end
  end

  // stage B: products
  logic [2*C-1:0] b_ps2_q, b_pf1_q;
  logic [2*C:0]   b_ps3_q;
  logic [C:0]     omf;
  logic [2:0]     b_sec_q;
  logic [C-1:0]   b_v_q;
  logic           b_black_q, b_grey_q;

  assign omf = TURN - {1'b0, a_f_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_ps2_q   <= a_s_q * a_f_q;
      b_ps3_q   <= {1'b0, a_s_q} * omf;
      b_pf1_q   <= a_v_q * a_oms_q;
      b_sec_q   <= a_sec_q;
      b_v_q     <= a_v_q;
      b_black_q <= a_black_q;
      b_grey_q  <= a_grey_q;
    end
  end

  // stage C: round s*f terms, second products
  logic [2*C:0] r2, r3;
  logic [C-1:0] t2, t3;
  logic [2*C-1:0] c_pf2_q, c_pf3_q;
  logic [C-1:0]   c_f1_q, c_v_q;
  logic [2:0]     c_sec_q;
  logic           c_black_q, c_grey_q;

  assign r2 = {1'b0, b_ps2_q} + HALF;
  assign r3 = b_ps3_q + HALF;
  assign t2 = r2[2*C-1:C];
  assign t3 = r3[2*C-1:C];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_pf2_q   <= b_v_q * (ONE - t2);
      c_pf3_q   <= b_v_q * (ONE - t3);
      c_f1_q    <= mul_fix(b_pf1_q);
      c_v_q     <= b_v_q;
      c_sec_q   <= b_sec_q;
      c_black_q <= b_black_q;
      c_grey_q  <= b_grey_q;
    end
  end

  // stage D: select by sector
  logic [C-1:0] f2, f3, r_d, g_d, bl_d;
  logic [C-1:0] red_q, green_q, blue_q;

  assign f2 = mul_fix(c_pf2_q);
  assign f3 = mul_fix(c_pf3_q);

  always_comb begin
    case (sector_e'(c_sec_q))
      SEC_RED_YEL: begin r_d = c_v_q;  g_d = f3;     bl_d = c_f1_q; end
      SEC_YEL_GRN: begin r_d = f2;     g_d = c_v_q;  bl_d = c_f1_q; end
      SEC_GRN_CYN: begin r_d = c_f1_q; g_d = c_v_q;  bl_d = f3;     end
      SEC_CYN_BLU: begin r_d = c_f1_q; g_d = f2;     bl_d = c_v_q;  end
      SEC_BLU_MAG: begin r_d = f3;     g_d = c_f1_q; bl_d = c_v_q;  end
      default:     begin r_d = c_v_q;  g_d = c_f1_q; bl_d = f2;     end
    endcase
    if (c_black_q) begin
      r_d = '0; g_d = '0; bl_d = '0;
    end else if (c_grey_q) begin
      r_d = c_v_q; g_d = c_v_q; bl_d = c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= r_d;
      green_q <= g_d;
      blue_q  <= bl_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign pay_o   = d_pay_q;

endmodule

>>> rtl/hsv_rgb_converter.sv
// Top level of the pixel RGB <-> HSV converter.
// Depends on hrc_pkg, hrc_hsv2rgb and hrc_div.
//
// Converts one pixel per word: kind 0 turns red/green/blue into hue/saturation/value,
// kind 1 turns hue/saturation/value into red/green/blue. Channels, saturation and value
// are unsigned fixed point with all ones as 1.0; hue is a fraction of a turn that wraps.
// The block takes a new word every clock unless the output is stalled. The pipeline is
// four stages of the HSV to RGB mix, two stages of max/min and dividend setup,
// CHANNEL_BITS + 1 stages of the two bit-per-stage dividers (saturation and hue), and
// the output register. A stall on the output freezes the whole pipeline; nothing is
// dropped or repeated.
module hsv_rgb_converter
  import hrc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic                    kind_i,
  input  logic [CHANNEL_BITS-1:0] in_red_or_hue_i,
  input  logic [CHANNEL_BITS-1:0] in_green_or_sat_i,
  input  logic [CHANNEL_BITS-1:0] in_blue_or_value_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [CHANNEL_BITS-1:0] out_hue_or_red_o,
  output logic [CHANNEL_BITS-1:0] out_sat_or_green_o,
  output logic [CHANNEL_BITS-1:0] out_value_or_blue_o
);

  localparam int C    = CHANNEL_BITS;
  localparam int HPW  = 3*C + 2;      // valid, kind, raw a/b/c
  localparam int DPW  = 4*C + 2;      // valid, kind, rgb result, max
  localparam int QB   = C + 1;
  localparam int HW   = 2*C + 3;      // hue dividend
  localparam int HDW  = C + 3;        // hue divisor 6d
  localparam int SW   = 2*C;          // saturation dividend
  localparam int SDW  = C;

  logic en;
  logic out_valid_q;

  // whole pipe advances unless a finished word is held by the sink
  assign en      = !(out_valid_q && stall_i);
  assign stall_o = !en;

  // ---- HSV to RGB front, carries the raw word along ----
  logic [C-1:0]   h_r, h_g, h_b;
  logic [HPW-1:0] h_pay;

  hrc_hsv2rgb #(
    .CHANNEL_BITS (C),
    .PW           (HPW)
  ) u_hsv2rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .hue_i   (in_red_or_hue_i),
    .sat_i   (in_green_or_sat_i),
    .val_i   (in_blue_or_value_i),
    .pay_i   ({valid_i && !stall_o, kind_i, in_red_or_hue_i,
                in_green_or_sat_i, in_blue_or_value_i}),
    .red_o   (h_r),
    .green_o (h_g),
    .blue_o  (h_b),
    .pay_o   (h_pay)
  );

  logic         h_vld, h_kind;
  logic [C-1:0] ra, ga, ba;
  assign {h_vld, h_kind, ra, ga, ba} = h_pay;

  // ---- stage 1: max, min, leading channel ----
  logic [C-1:0] mx, mn;
  max_ch_e      kch;
  logic [C-1:0] xs, ys;

  always_comb begin
    mx = ra;
    mn = ra;
    if (ga > mx) mx = ga;
    if (ba > mx) mx = ba;
    if (ga < mn) mn = ga;
    if (ba < mn) mn = ba;
    if (ra == mx) begin
      kch = MAX_RED; xs = ga; ys = ba;
    end else if (ga == mx) begin
      kch = MAX_GRN; xs = ba; ys = ra;
    end else begin
      kch = MAX_BLU; xs = ra; ys = ga;
    end
  end

  logic         s1_vld_q, s1_kind_q;
  logic [3*C-1:0] s1_rgb_q;
  logic [C-1:0] s1_mx_q, s1_d_q, s1_x_q, s1_y_q;
  max_ch_e      s1_k_q;
  logic         s1_grey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= h_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_kind_q <= h_kind;
      s1_rgb_q  <= {h_r, h_g, h_b};
      s1_mx_q   <= mx;
      s1_d_q    <= mx - mn;
      s1_x_q    <= xs;
      s1_y_q    <= ys;
      s1_k_q    <= kch;
      s1_grey_q <= (mx == mn);
    end
  end

  // ---- stage 2: hue numerator and both dividends ----
  logic [C+2:0] d2, d4, d6, nb, n;
  logic [C+1:0] d3;
  logic [C+3:0] nwrap;

  assign d2 = {2'b0, s1_d_q, 1'b0};
  assign d4 = {1'b0, s1_d_q, 2'b0};
  assign d6 = d2 + d4;
  assign d3 = {1'b0, s1_d_q, 1'b0} + {2'b0, s1_d_q};

  always_comb begin
    case (s1_k_q)
      MAX_RED: nb = {3'b0, s1_x_q};
      MAX_GRN: nb = d2 + {3'b0, s1_x_q};
      default: nb = d4 + {3'b0, s1_x_q};
    endcase
    // wrap negative hue by one full turn (6d)
    if (nb < {3'b0, s1_y_q}) nwrap = {1'b0, nb} + {1'b0, d6} - {4'b0, s1_y_q};
    else                     nwrap = {1'b0, nb} - {4'b0, s1_y_q};
    n = nwrap[C+2:0];
  end

  logic           s2_vld_q, s2_kind_q, s2_grey_q;
  logic [3*C-1:0] s2_rgb_q;
  logic [C-1:0]   s2_mx_q;
  logic [HW-1:0]  s2_hnum_q;
  logic [HDW-1:0] s2_hden_q;
  logic [SW-1:0]  s2_snum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_kind_q <= s1_kind_q;
      s2_grey_q <= s1_grey_q;
      s2_rgb_q  <= s1_rgb_q;
      s2_mx_q   <= s1_mx_q;
      s2_hnum_q <= {n, {C{1'b0}}} + HW'(d3);
      s2_hden_q <= d6;
      s2_snum_q <= {s1_d_q, {C{1'b0}}} - SW'(s1_d_q) + SW'(s1_mx_q >> 1);
    end
  end

  // ---- dividers ----
  logic [QB-1:0]  hq, sq;
  logic [DPW-1:0] dpay;
  logic           sgrey;

  hrc_div #(
    .W  (HW),
    .DW (HDW),
    .QB (QB),
    .PW (DPW)
  ) u_div_hue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .dividend_i (s2_hnum_q),
    .divisor_i  (s2_hden_q),
    .pay_i      ({s2_vld_q, s2_kind_q, s2_rgb_q, s2_mx_q}),
    .quot_o     (hq),
    .pay_o      (dpay)
  );

  hrc_div #(
    .W  (SW),
    .DW (SDW),
    .QB (QB),
    .PW (1)
  ) u_div_sat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .dividend_i (s2_snum_q),
    .divisor_i  (s2_mx_q),
    .pay_i      (s2_grey_q),
    .quot_o     (sq),
    .pay_o      (sgrey)
  );

  logic           q_vld, q_kind;
  logic [3*C-1:0] q_rgb;
  logic [C-1:0]   q_mx;
  assign {q_vld, q_kind, q_rgb, q_mx} = dpay;

  // ---- output register ----
  logic [C-1:0] o0_q, o1_q, o2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (q_kind == KIND_TO_RGB) begin
        {o0_q, o1_q, o2_q} <= q_rgb;
      end else begin
        o0_q <= sgrey ? '0 : hq[C-1:0];   // hue wraps modulo one turn
        o1_q <= sgrey ? '0 : sq[C-1:0];
        o2_q <= q_mx;
      end
    end
  end

  assign valid_o             = out_valid_q;
  assign out_hue_or_red_o    = o0_q;
  assign out_sat_or_green_o  = o1_q;
  assign out_value_or_blue_o = o2_q;

endmodule
